// ===== hdl/ccfd_pkg.sv =====
package ccfd_pkg;

  // Frame size limits and the counter widths that follow from them.
  localparam int MAX_ENCODED_LEN = 515;
  localparam int MAX_RAW_LEN     = 512;
  localparam int ENC_CNT_W       = $clog2(MAX_ENCODED_LEN + 1);
  localparam int RAW_CNT_W       = $clog2(MAX_RAW_LEN + 1);

  // Fixed field widths.
  localparam int BYTE_W    = 8;
  localparam int PLEN_W    = 9;
  localparam int MINLEN_W  = 10;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = MINLEN_W;

  // CRC-16/CCITT-FALSE.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [BYTE_W-1:0] FULL_GROUP_CODE = 8'hFF;

  localparam logic [MINLEN_W-1:0] MIN_RAW_LENGTH_RESET = 10'd8;
  localparam logic [MINLEN_W-1:0] MIN_RAW_LENGTH_FLOOR = 10'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RAW_LENGTH  = 1'b0,
    CFG_CRC_HIGH_FIRST  = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_GOOD      = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_MALFORMED = 3'd3,
    ST_SHORT     = 3'd4,
    ST_CRC       = 3'd5
  } status_t;

  typedef struct packed {
    logic [MINLEN_W-1:0] min_raw_length;
    logic                crc_high_byte_first;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_end;
    status_t           frame_status;
    logic [PLEN_W-1:0] payload_length;
  } result_t;

endpackage

// ===== hdl/cobs_crc16_frame_decoder_top.sv =====
// Channel   Direction  Transfer carries
// s_axis    in         one received byte, zero is the frame delimiter
// m_axis    out        one decoded payload byte, or the end-of-frame status
// cfg       in         register write, no handshake
//
// One byte is taken in every cycle while s_axis tready is high; its result,
// if any, is registered and shown on m_axis.
// Decoder state, register file and output valids clear on synchronous rst.
// A second result register catches one result while m_axis is stalled, so
// s_axis tready only drops once both result registers are occupied.
module cobs_crc16_frame_decoder_top (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
  // Output stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // [7:0] payload_byte,
                                                           // [16:8] payload_length,
                                                           // [23:17] zero
  output logic                              m_axis_tlast,  // frame_end
  output logic [2:0]                        m_axis_tuser,  // [2:0] frame_status
  // Configuration writes.
  input  logic                              cfg_we,
  input  logic [ccfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ccfd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ccfd_pkg::cfg_t    cfg;
  ccfd_pkg::result_t res;
  ccfd_pkg::result_t out_res;
  ccfd_pkg::result_t skid_res;
  logic              res_valid;
  logic              accept;
  logic              take;
  logic              out_valid;
  logic              skid_valid;
  logic              out_load;
  logic              skid_load;

  // Register file. Writes must only happen while the decoder is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_raw_length      <= ccfd_pkg::MIN_RAW_LENGTH_RESET;
      cfg.crc_high_byte_first <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccfd_pkg::CFG_MIN_RAW_LENGTH: begin
          cfg.min_raw_length <= cfg_data;
        end
        ccfd_pkg::CFG_CRC_HIGH_FIRST: begin
          cfg.crc_high_byte_first <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = out_valid && m_axis_tready;

  ccfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .rx_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // The output register reloads whenever it is empty or being emptied; it
  // takes the caught result first, since no new byte is accepted while one
  // is caught.
  assign out_load  = take || !out_valid;
  assign skid_load = out_valid && !take && res_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= skid_valid || res_valid;
      end
      if (skid_valid) begin
        skid_valid <= !take;
      end else begin
        skid_valid <= skid_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= skid_valid ? skid_res : res;
    end
    if (skid_load) begin
      skid_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_res.payload_length, out_res.payload_byte};
  assign m_axis_tlast  = out_res.frame_end;
  assign m_axis_tuser  = out_res.frame_status;

endmodule

// ===== hdl/ccfd_core.sv =====
module ccfd_core (
  input  logic                          clk,
  input  logic                          rst,
  input  ccfd_pkg::cfg_t                cfg,
  input  logic                          accept,
  input  logic [ccfd_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          res_valid,
  output ccfd_pkg::result_t             res
);

  // One byte through the CRC-16 shift register, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ ccfd_pkg::CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic [ccfd_pkg::ENC_CNT_W-1:0] enc_cnt, enc_cnt_next;
  logic                           overflow, overflow_next;
  logic                           malformed, malformed_next;
  logic [ccfd_pkg::BYTE_W-1:0]    grp_rem, grp_rem_next;
  logic                           grp_full, grp_full_next;
  logic                           zero_pend, zero_pend_next;
  logic [ccfd_pkg::BYTE_W-1:0]    hold0, hold0_next;
  logic [ccfd_pkg::BYTE_W-1:0]    hold1, hold1_next;
  logic [1:0]                     hold_fill, hold_fill_next;
  logic [ccfd_pkg::RAW_CNT_W-1:0] raw_cnt, raw_cnt_next;
  logic [15:0]                    crc, crc_next;

  logic                           push;
  logic [ccfd_pkg::BYTE_W-1:0]    push_byte;
  logic [ccfd_pkg::BYTE_W-1:0]    copy;
  logic [ccfd_pkg::RAW_CNT_W-1:0] raw_base;
  logic [ccfd_pkg::RAW_CNT_W:0]   raw_sum;
  logic                           skip_group;
  logic [ccfd_pkg::MINLEN_W-1:0]  min_eff;
  logic [15:0]                    supplied;
  logic [ccfd_pkg::RAW_CNT_W-1:0] plen_full;
  ccfd_pkg::status_t              status;

  // End-of-frame status and length.
  always_comb begin
    min_eff = (cfg.min_raw_length < ccfd_pkg::MIN_RAW_LENGTH_FLOOR) ?
              ccfd_pkg::MIN_RAW_LENGTH_FLOOR : cfg.min_raw_length;
    supplied = cfg.crc_high_byte_first ? {hold0, hold1} : {hold1, hold0};
    plen_full = (int'(raw_cnt) >= 2) ? raw_cnt - ccfd_pkg::RAW_CNT_W'(2) : '0;
    if (overflow) begin
      status = ccfd_pkg::ST_OVERFLOW;
    end else if (enc_cnt == '0) begin
      status = ccfd_pkg::ST_EMPTY;
    end else if (malformed || (grp_rem != '0)) begin
      status = ccfd_pkg::ST_MALFORMED;
    end else if (int'(raw_cnt) < int'(min_eff)) begin
      status = ccfd_pkg::ST_SHORT;
    end else if (supplied == crc) begin
      status = ccfd_pkg::ST_GOOD;
    end else begin
      status = ccfd_pkg::ST_CRC;
    end
  end

  // COBS step and hold-back line.
  always_comb begin
    enc_cnt_next   = enc_cnt;
    overflow_next  = overflow;
    malformed_next = malformed;
    grp_rem_next   = grp_rem;
    grp_full_next  = grp_full;
    zero_pend_next = zero_pend;
    hold0_next     = hold0;
    hold1_next     = hold1;
    hold_fill_next = hold_fill;
    raw_cnt_next   = raw_cnt;
    crc_next       = crc;
    push           = 1'b0;
    push_byte      = rx_byte;
    skip_group     = 1'b0;
    copy           = rx_byte - 8'd1;
    raw_base       = raw_cnt;
    raw_sum        = '0;
    res_valid      = 1'b0;
    res            = '0;

    if (accept) begin
      if (rx_byte == '0) begin
        res_valid          = 1'b1;
        res.frame_end      = 1'b1;
        res.frame_status   = status;
        res.payload_length = plen_full[ccfd_pkg::PLEN_W-1:0];
        enc_cnt_next   = '0;
        overflow_next  = 1'b0;
        malformed_next = 1'b0;
        grp_rem_next   = '0;
        grp_full_next  = 1'b0;
        zero_pend_next = 1'b0;
        hold_fill_next = '0;
        raw_cnt_next   = '0;
        crc_next       = ccfd_pkg::CRC_INIT;
      end else if (overflow ||
                   (enc_cnt >= ccfd_pkg::ENC_CNT_W'(ccfd_pkg::MAX_ENCODED_LEN))) begin
        overflow_next = 1'b1;
      end else begin
        enc_cnt_next = enc_cnt + 1'b1;
        if (!malformed) begin
          if (grp_rem == '0) begin
            // Code byte: first settle the implied zero of the last group.
            if (zero_pend) begin
              zero_pend_next = 1'b0;
              if (raw_cnt >= ccfd_pkg::RAW_CNT_W'(ccfd_pkg::MAX_RAW_LEN)) begin
                malformed_next = 1'b1;
                skip_group     = 1'b1;
              end else begin
                push      = 1'b1;
                push_byte = '0;
                raw_base  = raw_cnt + 1'b1;
              end
            end
            raw_sum = {1'b0, raw_base} + (ccfd_pkg::RAW_CNT_W + 1)'(copy);
            if (!skip_group) begin
              if (raw_sum > (ccfd_pkg::RAW_CNT_W + 1)'(ccfd_pkg::MAX_RAW_LEN)) begin
                malformed_next = 1'b1;
              end else begin
                grp_rem_next  = copy;
                grp_full_next = (rx_byte == ccfd_pkg::FULL_GROUP_CODE);
                if (copy == '0) begin
                  zero_pend_next = 1'b1;
                end
              end
            end
          end else begin
            push         = 1'b1;
            grp_rem_next = grp_rem - 1'b1;
            if (grp_rem == 8'd1) begin
              zero_pend_next = !grp_full;
            end
          end
        end
      end
    end

    if (push) begin
      raw_cnt_next = raw_cnt + 1'b1;
      if (hold_fill[1]) begin
        res_valid        = 1'b1;
        res.payload_byte = hold0;
        crc_next         = crc_byte(crc, hold0);
        hold0_next       = hold1;
        hold1_next       = push_byte;
      end else if (hold_fill[0]) begin
        hold1_next     = push_byte;
        hold_fill_next = 2'd2;
      end else begin
        hold0_next     = push_byte;
        hold_fill_next = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enc_cnt   <= '0;
      overflow  <= 1'b0;
      malformed <= 1'b0;
      grp_rem   <= '0;
      grp_full  <= 1'b0;
      zero_pend <= 1'b0;
      hold_fill <= '0;
      raw_cnt   <= '0;
      crc       <= ccfd_pkg::CRC_INIT;
    end else begin
      enc_cnt   <= enc_cnt_next;
      overflow  <= overflow_next;
      malformed <= malformed_next;
      grp_rem   <= grp_rem_next;
      grp_full  <= grp_full_next;
      zero_pend <= zero_pend_next;
      hold_fill <= hold_fill_next;
      raw_cnt   <= raw_cnt_next;
      crc       <= crc_next;
    end
  end

  // The held-back bytes are only read once both have been written.
  always_ff @(posedge clk) begin
    hold0 <= hold0_next;
    hold1 <= hold1_next;
  end

endmodule

// ===== tb/cobs_crc16_frame_decoder_top_tb.sv =====
// Self-checking bench for the COBS deframer with trailing CRC-16 check.
//
// Received bytes go in on s_axis, one transfer per byte. The bench keeps its
// own model of the decoder's frame state: group tracking, the implied zeros,
// the two held-back bytes and the running CRC. Every accepted byte is put
// through that model, and each decoded byte or end-of-frame status that it
// gives is queued. Every transfer on m_axis is then checked, field by field,
// against the oldest queued entry.
//
// The stimulus begins with directed frames: empty, good, short, bad CRC,
// truncated inside a group, a group that runs past the decoded size limit,
// an implied zero that would land past it, encoded overflow and the limits
// of both registers. A stretch with a long output stall follows, and then
// random traffic. Most of the random traffic is properly encoded frames with
// random content. The rest is register writes, cut-off frames, frames with a
// damaged byte, raw noise and bare delimiters. Registers are only written once
// the decoder is idle.

module cobs_crc16_frame_decoder_top_tb;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [23:0]                     m_axis_tdata;
  logic                            m_axis_tlast;
  logic [2:0]                      m_axis_tuser;
  logic                            cfg_we;
  logic [ccfd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ccfd_pkg::CFG_DATA_W-1:0] cfg_data;

  cobs_crc16_frame_decoder_top DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Decoder model: registers and per-frame state.
  logic [ccfd_pkg::MINLEN_W-1:0]  min_len_cfg;
  logic                           crc_hi_first_cfg;
  logic [ccfd_pkg::ENC_CNT_W-1:0] enc_count;
  logic                           overflow_seen;
  logic                           malformed_seen;
  logic [ccfd_pkg::BYTE_W-1:0]    group_left;
  logic                           full_group;
  logic                           implied_zero;
  logic [ccfd_pkg::BYTE_W-1:0]    held [2];
  logic [1:0]                     held_fill;
  logic [ccfd_pkg::RAW_CNT_W-1:0] decoded_count;
  logic [15:0]                    crc_acc;

  ccfd_pkg::result_t decoded_results [$];
  int                mismatch_count = 0;
  int                rx_bytes_sent = 0;

  // Random idling controls for the sender and the receiver.
  bit      calm_sender = 1'b0;
  bit      calm_receiver = 1'b0;
  int      long_hold_cycles = 0;

  // Scratch buffers for building a frame before it is sent.
  logic [7:0] frame_raw [$];
  logic [7:0] frame_enc [$];

  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++)
      c = c[15] ? ((c << 1) ^ ccfd_pkg::CRC_POLY) : (c << 1);
    return c;
  endfunction

  function void clear_frame_state();
    enc_count      = '0;
    overflow_seen  = 1'b0;
    malformed_seen = 1'b0;
    group_left     = '0;
    full_group     = 1'b0;
    implied_zero   = 1'b0;
    held_fill      = '0;
    decoded_count  = '0;
    crc_acc        = ccfd_pkg::CRC_INIT;
  endfunction

  // Push one decoded byte into the two-byte hold-back. Once it is full, the
  // oldest byte leaves as payload and goes into the CRC.
  function void hold_decoded(input logic [7:0] b);
    ccfd_pkg::result_t r;
    decoded_count++;
    if (held_fill >= 2) begin
      r.payload_byte   = held[0];
      r.frame_end      = 1'b0;
      r.frame_status   = ccfd_pkg::ST_GOOD;
      r.payload_length = '0;
      decoded_results.push_back(r);
      crc_acc = crc16_next(crc_acc, held[0]);
      held[0] = held[1];
      held[1] = b;
    end else if (held_fill == 1) begin
      held[1]   = b;
      held_fill = 2;
    end else begin
      held[0]   = b;
      held_fill = 1;
    end
  endfunction

  function void predict_rx_byte(input logic [7:0] b);
    ccfd_pkg::result_t             r;
    logic [ccfd_pkg::BYTE_W-1:0]   copy_len;
    logic [ccfd_pkg::MINLEN_W-1:0] floor_min;
    logic [15:0]                   supplied;
    if (b == 8'h00) begin
      floor_min = (min_len_cfg < ccfd_pkg::MIN_RAW_LENGTH_FLOOR) ?
                  ccfd_pkg::MIN_RAW_LENGTH_FLOOR : min_len_cfg;
      supplied  = crc_hi_first_cfg ? {held[0], held[1]} : {held[1], held[0]};
      r.payload_byte   = '0;
      r.frame_end      = 1'b1;
      r.payload_length = (decoded_count >= 2) ?
                         decoded_count[ccfd_pkg::PLEN_W-1:0] - 9'd2 : '0;
      if (overflow_seen)
        r.frame_status = ccfd_pkg::ST_OVERFLOW;
      else if (enc_count == 0)
        r.frame_status = ccfd_pkg::ST_EMPTY;
      else if (malformed_seen || group_left != 0)
        r.frame_status = ccfd_pkg::ST_MALFORMED;
      else if (decoded_count < floor_min)
        r.frame_status = ccfd_pkg::ST_SHORT;
      else if (supplied == crc_acc)
        r.frame_status = ccfd_pkg::ST_GOOD;
      else
        r.frame_status = ccfd_pkg::ST_CRC;
      decoded_results.push_back(r);
      clear_frame_state();
      return;
    end
    // Past the encoded limit nothing is counted or decoded until the delimiter.
    if (overflow_seen || enc_count >= ccfd_pkg::MAX_ENCODED_LEN) begin
      overflow_seen = 1'b1;
      return;
    end
    enc_count++;
    if (malformed_seen)
      return;
    if (group_left == 0) begin
      copy_len = b - 8'd1;
      if (implied_zero) begin
        implied_zero = 1'b0;
        if (decoded_count >= ccfd_pkg::MAX_RAW_LEN) begin
          malformed_seen = 1'b1;
          return;
        end
        hold_decoded(8'h00);
      end
      if (decoded_count + copy_len > ccfd_pkg::MAX_RAW_LEN) begin
        malformed_seen = 1'b1;
      end else begin
        group_left = copy_len;
        full_group = (b == ccfd_pkg::FULL_GROUP_CODE);
        if (copy_len == 0)
          implied_zero = 1'b1;
      end
    end else begin
      hold_decoded(b);
      group_left--;
      if (group_left == 0)
        implied_zero = !full_group;
    end
  endfunction

  // One byte transfer on s_axis, with an occasional idle burst ahead of it.
  task send_byte(input logic [7:0] b);
    if (!calm_sender && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    predict_rx_byte(b);
    rx_bytes_sent++;
  endtask

  // A code byte followed by n random non-zero data bytes.
  task send_group(input logic [7:0] code, input int n);
    send_byte(code);
    repeat (n) send_byte(8'($urandom_range(1, 255)));
  endtask

  task send_encoded();
    foreach (frame_enc[i]) send_byte(frame_enc[i]);
    send_byte(8'h00);
  endtask

  // COBS-encode frame_raw into frame_enc. A 0xFF group carries no implied
  // zero, and the last group's implied zero falls away at the delimiter.
  task encode_frame();
    int         code_pos;
    logic [7:0] code;
    frame_enc.delete();
    frame_enc.push_back(8'h00);
    code_pos = 0;
    code     = 8'h01;
    foreach (frame_raw[i]) begin
      if (frame_raw[i] == 8'h00) begin
        frame_enc[code_pos] = code;
        code_pos = frame_enc.size();
        frame_enc.push_back(8'h00);
        code = 8'h01;
      end else begin
        frame_enc.push_back(frame_raw[i]);
        code++;
        if (code == ccfd_pkg::FULL_GROUP_CODE) begin
          frame_enc[code_pos] = code;
          code_pos = frame_enc.size();
          frame_enc.push_back(8'h00);
          code = 8'h01;
        end
      end
    end
    frame_enc[code_pos] = code;
  endtask

  // Random payload plus its CRC, in the byte order the decoder is set to.
  task build_frame(input int payload_len, input int zero_pct, input bit corrupt_crc);
    logic [15:0] crc;
    logic [7:0]  b;
    frame_raw.delete();
    crc = ccfd_pkg::CRC_INIT;
    repeat (payload_len) begin
      b = ($urandom_range(0, 99) < zero_pct) ? 8'h00 : 8'($urandom_range(1, 255));
      frame_raw.push_back(b);
      crc = crc16_next(crc, b);
    end
    if (corrupt_crc)
      crc ^= 16'($urandom_range(1, 65535));
    if (crc_hi_first_cfg) begin
      frame_raw.push_back(crc[15:8]);
      frame_raw.push_back(crc[7:0]);
    end else begin
      frame_raw.push_back(crc[7:0]);
      frame_raw.push_back(crc[15:8]);
    end
    encode_frame();
  endtask

  task send_frame(input int payload_len, input int zero_pct, input bit corrupt_crc);
    build_frame(payload_len, zero_pct, corrupt_crc);
    send_encoded();
  endtask

  // Wait for every queued result to arrive. A byte that decodes to nothing
  // may still be in flight, so the wait goes on past the drain.
  task wait_until_drained();
    s_axis_tvalid <= 1'b0;
    while (decoded_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task write_reg(input ccfd_pkg::cfg_index_t idx,
                 input logic [ccfd_pkg::CFG_DATA_W-1:0] value);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ccfd_pkg::CFG_MIN_RAW_LENGTH)
      min_len_cfg = value;
    else
      crc_hi_first_cfg = value[0];
  endtask

  // Reset settings: minimum length 8, CRC low byte first.
  task test_frame_status_basics();
    send_byte(8'h00);                // empty frame straight after reset
    send_byte(8'h00);                // and a second delimiter back to back
    send_frame(6, 0, 1'b0);          // exactly the minimum, good
    send_frame(5, 0, 1'b0);          // one byte short
    send_frame(12, 30, 1'b1);        // CRC mismatch
    send_frame(14, 50, 1'b0);        // plenty of embedded zeros
    send_byte(8'h01);                // lone code byte: nothing decoded
    send_byte(8'h00);
    send_byte(8'h02);                // a single decoded byte
    send_byte(8'hFF);
    send_byte(8'h00);
    send_group(8'h05, 2);            // frame ends inside a group
    send_byte(8'h00);
  endtask

  task test_size_limits();
    // A group that would run past the decoded limit: 260 bytes decoded once
    // the implied zero is in, and a full group of 254 does not fit.
    send_group(ccfd_pkg::FULL_GROUP_CODE, 254);
    send_group(8'h06, 5);
    send_byte(ccfd_pkg::FULL_GROUP_CODE);
    send_byte(8'h00);
    // Code bytes of one only decode implied zeros. The limit is reached after
    // 513 of them, the next one finds a pending zero with no room left, and
    // the last one brings the encoded count exactly to its limit.
    repeat (ccfd_pkg::MAX_ENCODED_LEN) send_byte(8'h01);
    send_byte(8'h00);
    // One encoded byte too many; overflow outranks whatever the decoding did.
    repeat (ccfd_pkg::MAX_ENCODED_LEN + 1) send_byte(8'($urandom_range(1, 255)));
    send_byte(8'h00);
  endtask

  task test_min_length_register();
    // Values below two act as two.
    write_reg(ccfd_pkg::CFG_MIN_RAW_LENGTH, 10'd0);
    send_group(8'h02, 1);
    send_byte(8'h00);
    send_frame(0, 0, 1'b0);
    write_reg(ccfd_pkg::CFG_MIN_RAW_LENGTH, 10'd1);
    send_frame(0, 0, 1'b0);
    send_frame(0, 0, 1'b1);
    write_reg(ccfd_pkg::CFG_MIN_RAW_LENGTH, 10'd512);
    send_frame(20, 0, 1'b0);
    write_reg(ccfd_pkg::CFG_MIN_RAW_LENGTH, 10'd1023);
    send_frame(30, 10, 1'b0);
    write_reg(ccfd_pkg::CFG_MIN_RAW_LENGTH, 10'd2);
    send_frame(0, 0, 1'b0);
    send_frame(3, 0, 1'b0);
  endtask

  task test_crc_byte_order();
    write_reg(ccfd_pkg::CFG_CRC_HIGH_FIRST, 10'd1);
    send_frame(8, 20, 1'b0);
    send_frame(17, 0, 1'b0);
    send_frame(9, 10, 1'b1);
    // Only bit 0 of the write data counts for this register.
    write_reg(ccfd_pkg::CFG_CRC_HIGH_FIRST, 10'h3FE);
    send_frame(8, 20, 1'b0);
    send_frame(11, 0, 1'b1);
    write_reg(ccfd_pkg::CFG_MIN_RAW_LENGTH, ccfd_pkg::MIN_RAW_LENGTH_RESET);
  endtask

  // The receiver stops for a long time while bytes keep coming, so that both
  // result registers fill and s_axis is held off.
  task test_output_backpressure();
    calm_sender = 1'b1;
    long_hold_cycles = 300;
    send_frame(60, 10, 1'b0);
    send_frame(20, 10, 1'b1);
    calm_sender = 1'b0;
  endtask

  task test_random_traffic();
    int start_count;
    int pick;
    int len;
    int keep;
    start_count = rx_bytes_sent;
    while (rx_bytes_sent - start_count < 200) begin
      // The last stretch runs without idling on either side.
      if (rx_bytes_sent - start_count > 150) begin
        calm_sender   = 1'b1;
        calm_receiver = 1'b1;
      end
      pick = $urandom_range(0, 99);
      len  = $urandom_range(0, 99) < 90 ? $urandom_range(0, 20) : $urandom_range(21, 60);
      if (pick < 5) begin
        case ($urandom_range(0, 3))
          0:       write_reg(ccfd_pkg::CFG_MIN_RAW_LENGTH, 10'($urandom_range(0, 1023)));
          1:       write_reg(ccfd_pkg::CFG_MIN_RAW_LENGTH, 10'($urandom_range(21, 512)));
          default: write_reg(ccfd_pkg::CFG_MIN_RAW_LENGTH, 10'($urandom_range(2, 20)));
        endcase
        write_reg(ccfd_pkg::CFG_CRC_HIGH_FIRST, 10'($urandom_range(0, 1023)));
      end else if (pick < 72) begin
        send_frame(len, $urandom_range(0, 40), $urandom_range(0, 9) == 0);
      end else if (pick < 80) begin
        // Frame cut off somewhere, often inside a group.
        build_frame(len, $urandom_range(0, 40), 1'b0);
        keep = $urandom_range(1, frame_enc.size());
        while (frame_enc.size() > keep) void'(frame_enc.pop_back());
        send_encoded();
      end else if (pick < 88) begin
        // One damaged byte, which may well be a code byte.
        build_frame(len, $urandom_range(0, 40), 1'b0);
        frame_enc[$urandom_range(0, frame_enc.size() - 1)] = 8'($urandom_range(1, 255));
        send_encoded();
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 24)) send_byte(8'($urandom_range(0, 255)));
        send_byte(8'h00);
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'h00);
      end
    end
  endtask

  // Receiver: random stall bursts, the long hold-off on request, and none in
  // the final stretch.
  initial begin
    forever begin
      if (long_hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (long_hold_cycles) @(posedge clk);
        long_hold_cycles = 0;
      end else if (!calm_receiver && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    ccfd_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (decoded_results.size() == 0) begin
        $error("result with nothing predicted: tdata %h tlast %b tuser %0d",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatch_count++;
      end else begin
        want = decoded_results.pop_front();
        if (m_axis_tdata[7:0] !== want.payload_byte) begin
          $error("payload_byte: expected %0d, actual %0d", want.payload_byte, m_axis_tdata[7:0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.frame_end) begin
          $error("frame_end: expected %0d, actual %0d", want.frame_end, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tuser !== want.frame_status) begin
          $error("frame_status: expected %0d, actual %0d", want.frame_status, m_axis_tuser);
          mismatch_count++;
        end
        if (m_axis_tdata[16:8] !== want.payload_length) begin
          $error("payload_length: expected %0d, actual %0d",
                 want.payload_length, m_axis_tdata[16:8]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= ccfd_pkg::CFG_MIN_RAW_LENGTH;
    cfg_data      <= '0;
    min_len_cfg      = ccfd_pkg::MIN_RAW_LENGTH_RESET;
    crc_hi_first_cfg = 1'b0;
    held[0] = '0;
    held[1] = '0;
    clear_frame_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_frame_status_basics();
    test_size_limits();
    test_min_length_register();
    test_crc_byte_order();
    test_output_backpressure();
    test_random_traffic();

    wait_until_drained();
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ccfd_pkg.sv
hdl/ccfd_core.sv
hdl/cobs_crc16_frame_decoder_top.sv
tb/cobs_crc16_frame_decoder_top_tb.sv
